/* hw/rtl/fab_pkg.sv */
// Shared constants, command/status types and box overlap test for the box classifier.
package fab_pkg;

  // Fixed point format of weights and scaled coordinates
  localparam int FRAC_BITS = 16;
  localparam int WW        = FRAC_BITS + 1;
  localparam logic [WW-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WW:0]   HALF_Q = {3'b001, {(FRAC_BITS-1){1'b0}}};
  localparam logic [WW:0]   ONE_X  = {2'b01, {FRAC_BITS{1'b0}}};

  // Default store depths
  localparam int CAT_DEPTH_DEF = 64;
  localparam int REF_DEPTH_DEF = 64;

  // Port widths
  localparam int COORD_W     = 16;
  localparam int REF_IDX_W   = 6;
  localparam int CAT_W       = 6;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 17;
  localparam int ALPHA_W     = 17;
  localparam int BETA_W      = 17;
  localparam int REFCNT_W    = 7;

  // Input beat layout in tdata
  localparam int IN_X_LSB    = 0;
  localparam int IN_Y_LSB    = 16;
  localparam int IN_NEAR_BIT = 32;
  localparam int IN_RIDX_LSB = 33;
  localparam int IN_LOX_LSB  = 39;
  localparam int IN_LOY_LSB  = 56;
  localparam int IN_CX_LSB   = 73;
  localparam int IN_CY_LSB   = 90;

  // Opcodes carried in tuser
  localparam logic OPC_CLASSIFY = 1'b0;
  localparam logic OPC_LOAD     = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_MAP_W   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_MAP_H   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ALPHA   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BETA    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_REF_CNT = 3'd4;

  typedef struct packed {
    logic ld_pt;
    logic ld_ref;
    logic div_x;
    logic div_y;
    logic div_c;
    logic cap_x;
    logic cap_y;
    logic cap_c;
    logic j_clr;
    logic w_rd_j;
    logic sum_ld;
    logic scan_rd;
    logic best_clr;
    logic w_rd_best;
    logic m_ld_w;
    logic ref_rd;
    logic try_mark;
    logic sel_best;
    logic sel_near;
    logic sel_new;
    logic set_full;
    logic mul_step;
    logic w_wr;
    logic res_ld;
  } fab_cmd_t;

  typedef struct packed {
    logic div_done;
    logic n_zero;
    logic n_full;
    logic j_last;
    logic nearest;
    logic ext_ok;
    logic nref_zero;
    logic r_last;
    logic ovl;
    logic c_last;
    logic k_last;
    logic out_free;
    logic in_is_load;
  } fab_sts_t;

  // True if box m overlaps reference box r (lanes lo_x, lo_y, cx, cy)
  function automatic logic box_overlap(input logic [4*WW-1:0] m, input logic [4*WW-1:0] r);
    logic [WW-1:0] m0, m1, m2, m3, r0, r1, r2, r3;
    logic c0, c1, c2, c3, ux, uy, vx, vy, uvx, uvy;
    m0 = m[0*WW +: WW];
    m1 = m[1*WW +: WW];
    m2 = m[2*WW +: WW];
    m3 = m[3*WW +: WW];
    r0 = r[0*WW +: WW];
    r1 = r[1*WW +: WW];
    r2 = r[2*WW +: WW];
    r3 = r[3*WW +: WW];
    c0  = m0 < r0;
    ux  = c0 && (({1'b0, r0} + {1'b0, m2}) < ONE_X);
    c1  = m1 < r1;
    uy  = c1 && (({1'b0, r1} + {1'b0, m3}) < ONE_X);
    c2  = r2 > m2;
    vx  = (({1'b0, m0} + {1'b0, r2}) < ONE_X) && c2;
    c3  = r3 > m3;
    vy  = (({1'b0, m1} + {1'b0, r3}) < ONE_X) && c3;
    uvx = !c0 && !c2;
    uvy = !c1 && !c3;
    return (ux && uy) || (vx && vy) || ((ux || vx) && uvy) || ((uy || vy) && uvx);
  endfunction

endpackage

/* hw/rtl/fab_div.sv */
// Restoring divider, one quotient bit per cycle.
module fab_div
  import fab_pkg::*;
#(
  parameter int DVW = 20,
  parameter int QW  = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DVW+QW-1:0]  dividend,
  input  logic [DVW-1:0]     divisor,
  output logic [QW-1:0]      quot,
  output logic               done
);

  localparam int SW = DVW + QW;
  localparam int NW = $clog2(QW + 1);

  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic          ge;

  assign ge = rem_r >= dsh_r;

  // Load on start, then test and subtract one shifted divisor per cycle
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend;
      dsh_nxt = SW'(divisor) << (QW - 1);
      q_nxt   = '0;
      cnt_nxt = NW'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? rem_r - dsh_r : rem_r;
      dsh_nxt  = dsh_r >> 1;
      q_nxt    = {q_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - NW'(1);
      done_nxt = cnt_r == NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

/* hw/rtl/fab_dp.sv */
// Datapath: configuration, weight, reference and choice stores, divider, multiplier.
module fab_dp
  import fab_pkg::*;
#(
  parameter int CATEGORY_DEPTH = CAT_DEPTH_DEF,
  parameter int REF_DEPTH      = REF_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fab_cmd_t               cmd,
  output fab_sts_t               sts,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  localparam int CW   = $clog2(CATEGORY_DEPTH);
  localparam int CNTW = $clog2(CATEGORY_DEPTH + 1);
  localparam int RAW  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int RCW  = $clog2(REF_DEPTH + 1);
  localparam int NUMW = WW + 2;
  localparam int DVW  = WW + 3;
  localparam int QW   = WW;
  localparam int SW   = DVW + QW;
  localparam int ROWW = 4 * WW;

  // Configuration
  logic [COORD_W-1:0]  map_w_r, map_h_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [BETA_W-1:0]   beta_r;
  logic [REFCNT_W-1:0] ref_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r   <= COORD_W'(1);
      map_h_r   <= COORD_W'(1);
      alpha_r   <= ALPHA_W'(1);
      beta_r    <= {1'b1, {FRAC_BITS{1'b0}}};
      ref_cnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAP_W:   map_w_r   <= cfg_wdata[COORD_W-1:0];
        CFG_MAP_H:   map_h_r   <= cfg_wdata[COORD_W-1:0];
        CFG_ALPHA:   alpha_r   <= cfg_wdata[ALPHA_W-1:0];
        CFG_BETA:    beta_r    <= cfg_wdata[BETA_W-1:0];
        CFG_REF_CNT: ref_cnt_r <= cfg_wdata[REFCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Point and scaled input vector
  logic [COORD_W-1:0] x_r, y_r;
  logic               near_r;
  logic [WW-1:0]      ix_r, iy_r;
  logic [WW-1:0]      inp [4];
  logic [COORD_W-1:0] divx, divy;
  logic               x_sat, y_sat;

  assign divx  = (map_w_r == '0) ? COORD_W'(1) : map_w_r;
  assign divy  = (map_h_r == '0) ? COORD_W'(1) : map_h_r;
  assign x_sat = x_r >= divx;
  assign y_sat = y_r >= divy;
  assign inp[0] = ix_r;
  assign inp[1] = iy_r;
  assign inp[2] = ONE_Q - ix_r;
  assign inp[3] = ONE_Q - iy_r;

  // Divider operand selection
  logic [SW-1:0]  div_dnd;
  logic [DVW-1:0] div_dsr;
  logic [QW-1:0]  quot;
  logic           div_done;
  logic [NUMW-1:0] num_r;
  logic [DVW-1:0]  den_r;

  always_comb begin
    div_dnd = '0;
    div_dsr = DVW'(1);
    if (cmd.div_x) begin
      div_dnd = x_sat ? '0 : (SW'(x_r) << FRAC_BITS);
      div_dsr = DVW'(divx);
    end else if (cmd.div_y) begin
      div_dnd = y_sat ? '0 : (SW'(y_r) << FRAC_BITS);
      div_dsr = DVW'(divy);
    end else if (cmd.div_c) begin
      div_dnd = SW'(num_r) << FRAC_BITS;
      div_dsr = den_r;
    end
  end

  fab_div #(.DVW(DVW), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_x | cmd.div_y | cmd.div_c),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_pt) begin
      x_r    <= in_tdata[IN_X_LSB +: COORD_W];
      y_r    <= in_tdata[IN_Y_LSB +: COORD_W];
      near_r <= in_tdata[IN_NEAR_BIT];
    end
    if (cmd.cap_x) ix_r <= x_sat ? ONE_Q : quot;
    if (cmd.cap_y) iy_r <= y_sat ? ONE_Q : quot;
  end

  // Category counters
  logic [CNTW-1:0] act_cnt_r, j_r, c_r;
  logic [CW-1:0]   best_r, sel_r, sj_r;
  logic [1:0]      k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cnt_r <= '0;
    end else if (cmd.sel_new) begin
      act_cnt_r <= act_cnt_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.cap_c || cmd.scan_rd) begin
      j_r <= j_r + CNTW'(1);
    end
    if (cmd.ld_pt) begin
      c_r <= '0;
    end else if (cmd.try_mark) begin
      c_r <= c_r + CNTW'(1);
    end
  end

  // Weight store, one row of four lanes per category
  logic [ROWW-1:0] wmem [CATEGORY_DEPTH];
  logic [ROWW-1:0] wrd_r;
  logic [WW-1:0]   nw_r [4];
  logic [CW-1:0]   w_raddr;

  assign w_raddr = cmd.w_rd_best ? best_r : j_r[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.w_rd_j || cmd.w_rd_best) wrd_r <= wmem[w_raddr];
    if (cmd.w_wr) wmem[sel_r] <= {nw_r[3], nw_r[2], nw_r[1], nw_r[0]};
  end

  // Choice numerator and denominator
  logic [NUMW-1:0] num_sum;
  logic [DVW-1:0]  den_sum;
  logic [WW-1:0]   wl;

  always_comb begin
    num_sum = '0;
    den_sum = DVW'(alpha_r);
    wl      = '0;
    for (int i = 0; i < 4; i++) begin
      wl      = wrd_r[i*WW +: WW];
      num_sum = num_sum + NUMW'((wl < inp[i]) ? wl : inp[i]);
      den_sum = den_sum + DVW'(wl);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      num_r <= num_sum;
      den_r <= den_sum;
    end
  end

  // Choice scratch and tried marks
  logic [QW-1:0] smem [CATEGORY_DEPTH];
  logic [QW-1:0] srd_r, best_val_r;
  logic          sv_r, have_r;
  logic [CATEGORY_DEPTH-1:0] tried_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_c) smem[j_r[CW-1:0]] <= (den_r == '0) ? '0 : quot;
    if (cmd.scan_rd) srd_r <= smem[j_r[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else begin
      sv_r <= cmd.scan_rd;
    end
  end

  // Scan for best untried choice, first index wins on ties
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) sj_r <= j_r[CW-1:0];
    if (cmd.cap_c) tried_r[j_r[CW-1:0]] <= 1'b0;
    if (cmd.try_mark) tried_r[best_r] <= 1'b1;
    if (cmd.best_clr) begin
      have_r <= 1'b0;
    end else if (sv_r && !tried_r[sj_r] && (!have_r || srd_r > best_val_r)) begin
      have_r     <= 1'b1;
      best_r     <= sj_r;
      best_val_r <= srd_r;
    end
  end

  // Candidate box and reference check
  logic [WW-1:0]  m_r [4];
  logic [ROWW-1:0] m_row;
  logic [ROWW-1:0] rmem [REF_DEPTH];
  logic [ROWW-1:0] rrd_r;
  logic            rv_r, ovl_r;
  logic [RCW-1:0]  r_r, nref;
  logic            ld_ok;
  logic [WW:0]     ext_x, ext_y;

  assign m_row = {m_r[3], m_r[2], m_r[1], m_r[0]};
  assign nref  = (int'(ref_cnt_r) > REF_DEPTH) ? RCW'(REF_DEPTH) : RCW'(ref_cnt_r);
  assign ld_ok = int'(in_tdata[IN_RIDX_LSB +: REF_IDX_W]) < REF_DEPTH;
  assign ext_x = {1'b0, m_r[0]} + {1'b0, m_r[2]};
  assign ext_y = {1'b0, m_r[1]} + {1'b0, m_r[3]};

  always_ff @(posedge clk) begin
    if (cmd.ld_ref && ld_ok) begin
      rmem[RAW'(in_tdata[IN_RIDX_LSB +: REF_IDX_W])] <= {
        in_tdata[IN_CY_LSB +: WW], in_tdata[IN_CX_LSB +: WW],
        in_tdata[IN_LOY_LSB +: WW], in_tdata[IN_LOX_LSB +: WW]};
    end
    if (cmd.ref_rd) rrd_r <= rmem[r_r[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.ref_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.m_ld_w) begin
      for (int i = 0; i < 4; i++) begin
        m_r[i] <= (wrd_r[i*WW +: WW] < inp[i]) ? wrd_r[i*WW +: WW] : inp[i];
      end
    end else if (cmd.sel_new) begin
      for (int i = 0; i < 4; i++) m_r[i] <= inp[i];
    end
    if (cmd.m_ld_w) begin
      r_r   <= '0;
      ovl_r <= 1'b0;
    end else begin
      if (cmd.ref_rd) r_r <= r_r + RCW'(1);
      if (rv_r && box_overlap(m_row, rrd_r)) ovl_r <= 1'b1;
    end
  end

  // Learning: one lane through the multiplier per cycle
  logic [2*WW-1:0]       prod;
  logic [2*WW-FRAC_BITS-1:0] prod_sh;

  assign prod    = (2*WW)'(beta_r) * (2*WW)'(m_r[k_r]);
  assign prod_sh = prod[2*WW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.sel_best || cmd.sel_new) begin
      k_r <= '0;
    end else if (cmd.mul_step) begin
      k_r <= k_r + 2'd1;
    end
    if (cmd.mul_step) begin
      nw_r[k_r] <= (prod_sh > (2*WW-FRAC_BITS)'(ONE_Q)) ? ONE_Q : prod_sh[WW-1:0];
    end
  end

  // Result held until the output register is free
  logic [CW-1:0] res_cat_r;
  logic          res_new_r, res_full_r;

  always_ff @(posedge clk) begin
    if (cmd.sel_best || cmd.sel_near) begin
      sel_r      <= best_r;
      res_cat_r  <= best_r;
      res_new_r  <= 1'b0;
      res_full_r <= 1'b0;
    end else if (cmd.sel_new) begin
      sel_r      <= act_cnt_r[CW-1:0];
      res_cat_r  <= act_cnt_r[CW-1:0];
      res_new_r  <= 1'b1;
      res_full_r <= 1'b0;
    end else if (cmd.set_full) begin
      res_cat_r  <= '0;
      res_new_r  <= 1'b0;
      res_full_r <= 1'b1;
    end
  end

  // Output register
  logic             out_valid_r;
  logic [CAT_W-1:0] out_cat_r;
  logic             out_new_r, out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_cat_r  <= CAT_W'(res_cat_r);
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_cat_r);
  assign out_tuser  = {out_full_r, out_new_r};

  // Status to the controller
  assign sts.div_done   = div_done;
  assign sts.n_zero     = act_cnt_r == '0;
  assign sts.n_full     = int'(act_cnt_r) == CATEGORY_DEPTH;
  assign sts.j_last     = (j_r + CNTW'(1)) == act_cnt_r;
  assign sts.nearest    = near_r;
  assign sts.ext_ok     = (ext_x >= HALF_Q) && (ext_y >= HALF_Q);
  assign sts.nref_zero  = nref == '0;
  assign sts.r_last     = (r_r + RCW'(1)) == nref;
  assign sts.ovl        = ovl_r;
  assign sts.c_last     = (c_r + CNTW'(1)) == act_cnt_r;
  assign sts.k_last     = k_r == 2'd3;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.in_is_load = in_tuser == OPC_LOAD;

endmodule

/* hw/rtl/fab_ctrl.sv */
// Controller state machine sequencing scaling, choice, search, vigilance and learning.
module fab_ctrl
  import fab_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  fab_sts_t sts,
  output fab_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SX   = 5'd1;
  localparam logic [4:0] S_SXW  = 5'd2;
  localparam logic [4:0] S_SYW  = 5'd3;
  localparam logic [4:0] S_CRD  = 5'd4;
  localparam logic [4:0] S_CSUM = 5'd5;
  localparam logic [4:0] S_CDIV = 5'd6;
  localparam logic [4:0] S_CDW  = 5'd7;
  localparam logic [4:0] S_SC0  = 5'd8;
  localparam logic [4:0] S_SCAN = 5'd9;
  localparam logic [4:0] S_SCL  = 5'd10;
  localparam logic [4:0] S_PICK = 5'd11;
  localparam logic [4:0] S_MIN  = 5'd12;
  localparam logic [4:0] S_RRD  = 5'd13;
  localparam logic [4:0] S_RL   = 5'd14;
  localparam logic [4:0] S_RDEC = 5'd15;
  localparam logic [4:0] S_NEWC = 5'd16;
  localparam logic [4:0] S_UPD  = 5'd17;
  localparam logic [4:0] S_WR   = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  logic [4:0] state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (sts.in_is_load) begin
            cmd.ld_ref = 1'b1;
          end else begin
            cmd.ld_pt = 1'b1;
            state_nxt = S_SX;
          end
        end
      end
      S_SX: begin
        cmd.div_x = 1'b1;
        state_nxt = S_SXW;
      end
      S_SXW: begin
        if (sts.div_done) begin
          cmd.cap_x = 1'b1;
          cmd.div_y = 1'b1;
          state_nxt = S_SYW;
        end
      end
      S_SYW: begin
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          cmd.j_clr = 1'b1;
          state_nxt = sts.n_zero ? S_NEWC : S_CRD;
        end
      end
      S_CRD: begin
        cmd.w_rd_j = 1'b1;
        state_nxt  = S_CSUM;
      end
      S_CSUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = S_CDIV;
      end
      S_CDIV: begin
        cmd.div_c = 1'b1;
        state_nxt = S_CDW;
      end
      S_CDW: begin
        if (sts.div_done) begin
          cmd.cap_c = 1'b1;
          state_nxt = sts.j_last ? S_SC0 : S_CRD;
        end
      end
      S_SC0: begin
        cmd.j_clr    = 1'b1;
        cmd.best_clr = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.j_last) state_nxt = S_SCL;
      end
      S_SCL: state_nxt = S_PICK;
      S_PICK: begin
        if (sts.nearest) begin
          cmd.sel_near = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.w_rd_best = 1'b1;
          state_nxt     = S_MIN;
        end
      end
      S_MIN: begin
        cmd.m_ld_w = 1'b1;
        state_nxt  = S_RRD;
      end
      S_RRD: begin
        if (!sts.ext_ok || sts.nref_zero) begin
          state_nxt = S_RDEC;
        end else begin
          cmd.ref_rd = 1'b1;
          if (sts.r_last) state_nxt = S_RL;
        end
      end
      S_RL: state_nxt = S_RDEC;
      S_RDEC: begin
        if (sts.ext_ok && !sts.ovl) begin
          cmd.sel_best = 1'b1;
          state_nxt    = S_UPD;
        end else begin
          cmd.try_mark = 1'b1;
          state_nxt    = sts.c_last ? S_NEWC : S_SC0;
        end
      end
      S_NEWC: begin
        if (sts.n_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.sel_new = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.mul_step = 1'b1;
        if (sts.k_last) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.w_wr  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/fuzzy_art_box_classifier.sv */
// Top level of the fuzzy ART box classifier: controller plus datapath.
//
// Input stream: one beat is either a reference box load (tuser = 1) or a point
// to classify (tuser = 0). A load leaves the block idle and gives no result.
// A classify beat gives exactly one result beat: the category, whether it was
// newly opened, and a full flag when no category resonated and none is free.
// Configuration writes are registered; the user must make them only while idle;
// the block does not enforce this. A classify with n active categories and R
// reference boxes runs the scaling, the choice value of each category (one
// shared 17-step divider), then per tried candidate a scan of the n choices and
// a check of the R boxes (one scratch read and one reference read per cycle),
// and learning on the single multiplier. One item is in flight at a time.
// The result sits in an output register; the next beat is taken while it waits,
// and a finished item stalls only until that register frees.
// Reset clears the category count and sets the configuration to defaults;
// weight and choice stores need no clearing, as no unwritten row is ever read.
module fuzzy_art_box_classifier
  import fab_pkg::*;
#(
  parameter int CATEGORY_DEPTH = CAT_DEPTH_DEF,
  parameter int REF_DEPTH      = REF_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x, y, nearest_only, ref_index, ref_lo_x, ref_lo_y, ref_cx, ref_cy, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // category, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // is_new, full_res
  output logic [1:0]             out_tuser
);

  fab_cmd_t cmd;
  fab_sts_t sts;

  fab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fab_dp #(
    .CATEGORY_DEPTH (CATEGORY_DEPTH),
    .REF_DEPTH      (REF_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/fab_checker.sv */
// Port-level checks for the box classifier, bound to the top level.
module fab_checker
  import fab_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Drop the result after reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Busy after a classify beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OPC_CLASSIFY) |=> !in_tready)
    else $error("classify beat did not occupy the block");

  // Full result carries category zero and no new flag
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("full result with category or new flag");

  // Load beats never block the input
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OPC_LOAD) |=> in_tready)
    else $error("load beat stalled the input");

endmodule

bind fuzzy_art_box_classifier fab_checker u_fab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/tb_top.sv */
// Self-checking testbench for the fuzzy ART box classifier: random stream traffic and a scoreboard.

class fab_scoreboard;
  typedef struct {
    bit [5:0] cat;
    bit       fresh;
    bit       full;
  } verdict_t;

  localparam longint unsigned ONE  = 64'd65536;
  localparam longint unsigned HALF = 64'd32768;
  localparam int NCAT = 64;
  localparam int NREF = 64;

  bit [16:0] cat_w[NCAT][4];
  int        n_active;
  bit [16:0] ref_box[NREF][4];
  bit [15:0] map_w, map_h;
  bit [16:0] alpha_q, beta_q;
  bit [6:0]  ref_cnt;
  verdict_t  pending[$];
  int        errors;

  function new();
    foreach (cat_w[j, i]) cat_w[j][i] = 17'(ONE);
    n_active = 0;
    map_w    = 1;
    map_h    = 1;
    alpha_q  = 1;
    beta_q   = 17'd65536;
    ref_cnt  = 0;
    errors   = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [16:0] val);
    case (idx)
      fab_pkg::CFG_MAP_W:   map_w   = val[15:0];
      fab_pkg::CFG_MAP_H:   map_h   = val[15:0];
      fab_pkg::CFG_ALPHA:   alpha_q = val;
      fab_pkg::CFG_BETA:    beta_q  = val;
      fab_pkg::CFG_REF_CNT: ref_cnt = val[6:0];
      default: ;
    endcase
  endfunction

  // Scale a coordinate to the unit interval, zero divisor acts as one
  function longint unsigned scale(bit [15:0] v, bit [15:0] div);
    longint unsigned q;
    q = (longint'(v) << 16) / (div == 0 ? 1 : div);
    return q > ONE ? ONE : q;
  endfunction

  // Work out what an accepted input beat should produce
  function void note_beat(bit op, bit [15:0] x, bit [15:0] y, bit near, bit [5:0] idx,
                          bit [16:0] b[4]);
    longint unsigned p[4], m[4], choice[NCAT], num, den, v;
    longint unsigned r0, r1, r2, r3;
    bit tried[NCAT];
    bit found, have, ovl, c0, c1, c2, c3, ux, uy, vx, vy, uvx, uvy;
    int n, best, sel, nr;
    verdict_t res;
    if (op == fab_pkg::OPC_LOAD) begin
      for (int i = 0; i < 4; i++) ref_box[idx][i] = b[i];
      return;
    end
    p[0] = scale(x, map_w);
    p[1] = scale(y, map_h);
    p[2] = ONE - p[0];
    p[3] = ONE - p[1];
    n = n_active;
    found = 0;
    best = 0;
    res = '{cat: 0, fresh: 0, full: 0};
    for (int j = 0; j < n; j++) begin
      num = 0;
      den = alpha_q;
      for (int i = 0; i < 4; i++) begin
        num += cat_w[j][i] < p[i] ? cat_w[j][i] : p[i];
        den += cat_w[j][i];
      end
      choice[j] = den != 0 ? (num << 16) / den : 0;
      tried[j] = 0;
    end
    // Try candidates best first, lowest index on ties
    for (int c = 0; c < n && !found; c++) begin
      have = 0;
      for (int j = 0; j < n; j++) begin
        if (!tried[j] && (!have || choice[j] > choice[best])) begin
          best = j;
          have = 1;
        end
      end
      if (near) begin
        res.cat = 6'(best);
        pending.push_back(res);
        return;
      end
      for (int i = 0; i < 4; i++) m[i] = cat_w[best][i] < p[i] ? cat_w[best][i] : p[i];
      ovl = 0;
      nr = ref_cnt > NREF ? NREF : ref_cnt;
      for (int k = 0; k < nr; k++) begin
        r0 = ref_box[k][0];
        r1 = ref_box[k][1];
        r2 = ref_box[k][2];
        r3 = ref_box[k][3];
        c0 = m[0] < r0;
        ux = c0 && (r0 + m[2] < ONE);
        c1 = m[1] < r1;
        uy = c1 && (r1 + m[3] < ONE);
        c2 = r2 > m[2];
        vx = (m[0] + r2 < ONE) && c2;
        c3 = r3 > m[3];
        vy = (m[1] + r3 < ONE) && c3;
        uvx = !c0 && !c2;
        uvy = !c1 && !c3;
        if ((ux && uy) || (vx && vy) || ((ux || vx) && uvy) || ((uy || vy) && uvx)) ovl = 1;
      end
      if (m[0] + m[2] >= HALF && m[1] + m[3] >= HALF && !ovl) found = 1;
      else tried[best] = 1;
    end
    if (found) begin
      sel = best;
    end else if (n < NCAT) begin
      sel = n;
      n_active = n + 1;
      res.fresh = 1;
    end else begin
      res.full = 1;
      pending.push_back(res);
      return;
    end
    // Learn: weights become beta times the box, capped at one
    for (int i = 0; i < 4; i++) begin
      v = (longint'(beta_q) * (cat_w[sel][i] < p[i] ? cat_w[sel][i] : p[i])) >> 16;
      cat_w[sel][i] = 17'(v > ONE ? ONE : v);
    end
    res.cat = 6'(sel);
    pending.push_back(res);
  endfunction

  // Compare a result beat with the oldest expectation
  function void check_beat(bit [5:0] cat, bit fresh, bit full);
    verdict_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: cat=%0d new=%0b full=%0b",
                                 cat, fresh, full);
      return;
    end
    e = pending.pop_front();
    if (e.cat != cat || e.fresh != fresh || e.full != full) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: exp cat=%0d new=%0b full=%0b, got cat=%0d new=%0b full=%0b",
                 e.cat, e.fresh, e.full, cat, fresh, full);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fab_pkg::*;

  localparam longint LIMIT = 64'd60_000_000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  fab_scoreboard sb = new();
  bit            calm = 1'b0;
  longint        cycles = 0;
  int            mw_cur = 1;

  fuzzy_art_box_classifier dut (.*);

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, check every accepted beat
  always @(negedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 26);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata[5:0], out_tuser[0], out_tuser[1]);

  // Hold off until every expected result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic send_beat(bit op, bit [15:0] x, bit [15:0] y, bit near, bit [5:0] idx,
                           bit [16:0] b[4]);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser <= op;
    in_tdata <= {5'b0, b[3], b[2], b[1], b[0], idx, near, y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, x, y, near, idx, b);
    @(negedge clk);
  endtask

  task automatic classify(bit [15:0] x, bit [15:0] y, bit near);
    bit [16:0] b[4];
    foreach (b[i]) b[i] = 17'($urandom);
    send_beat(OPC_CLASSIFY, x, y, near, 6'($urandom), b);
  endtask

  // Reference box: mostly in range, sometimes any 17-bit value
  task automatic load_box(bit [5:0] idx);
    bit [16:0] b[4];
    foreach (b[i]) b[i] = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
    send_beat(OPC_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), idx, b);
  endtask

  task automatic setup(int mw, int mh, int al, int be, int rc);
    drain();
    write_reg(CFG_MAP_W, CFG_DW'(mw));
    write_reg(CFG_MAP_H, CFG_DW'(mh));
    write_reg(CFG_ALPHA, CFG_DW'(al));
    write_reg(CFG_BETA, CFG_DW'(be));
    write_reg(CFG_REF_CNT, CFG_DW'(rc));
    mw_cur = mw;
  endtask

  // Point near the map, now and then anywhere
  function automatic bit [15:0] coord(int span);
    int hi;
    hi = span + span / 8;
    if (hi > 65535) hi = 65535;
    return $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, hi));
  endfunction

  initial begin
    int cfgs[6][5];
    bit [16:0] edge_box[4];
    cfgs = '{'{1000, 1000, 1, 65536, 0},
             '{40000, 300, 65536, 60000, 3},
             '{65535, 65535, 0, 65536, 127},
             '{0, 0, 0, 0, 0},
             '{0, 0, 131071, 131071, 64},
             '{500, 700, 20, 0, 1}};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: nearest with nothing active, corners with reset scaling
    classify(16'd0, 16'd0, 1'b1);
    classify(16'd0, 16'd0, 1'b0);
    classify(16'hFFFF, 16'hFFFF, 1'b0);
    classify(16'hFFFF, 16'd0, 1'b1);
    classify(16'd1, 16'hFFFF, 1'b0);
    // Fill every reference slot, extremes in the first two
    edge_box = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF};
    send_beat(OPC_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 6'd0, edge_box);
    edge_box = '{17'd0, 17'd0, 17'd0, 17'd0};
    send_beat(OPC_LOAD, 16'd0, 16'd0, 1'b0, 6'd1, edge_box);
    for (int k = 2; k < 64; k++) load_box(6'(k));
    // Zero divisors act as one, large ref count clamps
    setup(0, 0, 65536, 131071, 127);
    classify(16'd0, 16'd1, 1'b0);
    classify(16'hFFFF, 16'h8000, 1'b0);
    classify(16'h8000, 16'h8000, 1'b1);

    // Random phases, the first without idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) setup($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 10));
      else setup(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3], cfgs[ph][4]);
      calm = (ph == 0);
      for (int k = 0; k < 163; k++) begin
        if ($urandom_range(0, 99) < 15) load_box(6'($urandom));
        else classify(coord(mw_cur), coord(mw_cur), $urandom_range(0, 99) < 15);
      end
    end
    calm = 1'b0;

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* fuzzy_art_box_classifier.f */
hw/rtl/fab_pkg.sv
hw/rtl/fab_div.sv
hw/rtl/fab_dp.sv
hw/rtl/fab_ctrl.sv
hw/rtl/fuzzy_art_box_classifier.sv
hw/rtl/fab_checker.sv
tb/tb_top.sv
